>>> rtl/core/ffdl_pkg.sv
// ----------------------------------------------------------------------------
// ffdl_pkg
// Shared types, constants and arithmetic helpers for the fractional delay line.
// ----------------------------------------------------------------------------
package ffdl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = 16;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int PADDR_W     = 5;

  localparam logic [16:0] UNITY     = 17'd65536;
  localparam logic [15:0] FB_MAX    = 16'd62259;
  localparam logic [31:0] MAX_DELAY = 32'(DEPTH - 2) << 16;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_TARGET_DELAY = 5'd0;
  localparam logic [PADDR_W-1:0] REG_MIN_DELAY    = 5'd4;
  localparam logic [PADDR_W-1:0] REG_TARGET_FB    = 5'd8;
  localparam logic [PADDR_W-1:0] REG_TARGET_MIX   = 5'd12;
  localparam logic [PADDR_W-1:0] REG_COEFF        = 5'd16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [31:0] target_delay;
    logic [31:0] min_delay;
    logic [15:0] target_feedback;
    logic [16:0] target_mix;
    logic [16:0] coeff;
  } cfg_t;

  // early target writes, applied to the running values before the first item
  typedef struct packed {
    logic        delay_en;
    logic [31:0] delay;
    logic        fb_en;
    logic [16:0] fb;
    logic        mix_en;
    logic [16:0] mix;
  } cfg_load_t;

  // (x + half) >> 16 with floor
  function automatic logic signed [25:0] round16(input logic signed [41:0] x);
    logic signed [41:0] t;
    begin
      t = x + 42'sd32768;
      round16 = t[41:16];
    end
  endfunction

  function automatic sample_t sat27(input logic signed [26:0] v);
    begin
      if (v > 27'sd8388607) sat27 = 24'sh7FFFFF;
      else if (v < -27'sd8388608) sat27 = 24'sh800000;
      else sat27 = v[23:0];
    end
  endfunction

  function automatic logic [31:0] smooth(input logic [31:0] cur, input logic [31:0] tgt,
                                         input logic [16:0] c);
    logic [31:0] diff;
    logic [48:0] prod;
    begin
      diff = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
      prod = {17'd0, diff} * {32'd0, c};
      smooth = (tgt >= cur) ? (cur + prod[47:16]) : (cur - prod[47:16]);
    end
  endfunction

endpackage

>>> rtl/core/ffdl_front.sv
// ----------------------------------------------------------------------------
// ffdl_front
// Two-entry input queue that accepts samples while the back end works.
// ----------------------------------------------------------------------------
module ffdl_front import ffdl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t dry_sample,
  output logic    q_valid,
  output sample_t q_data,
  input  logic    q_pop
);

  sample_t     slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dry_sample;
    end
  end

endmodule

>>> rtl/core/ffdl_back.sv
// ----------------------------------------------------------------------------
// ffdl_back
// Sequencer: parameter smoothing, ring read and interpolation, feedback
// write and wet/dry mix, with a registered output.
// ----------------------------------------------------------------------------
module ffdl_back import ffdl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cfg_load_t load,
  input  logic      q_valid,
  input  sample_t   q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output sample_t   wet_sample
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SMOOTH = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_RDLO   = 4'd3;
  localparam logic [3:0] S_RDHI   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_ROUND  = 4'd6;
  localparam logic [3:0] S_PROD   = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;

  logic [3:0]         state;
  logic [31:0]        cur_delay;
  logic [16:0]        cur_fb;
  logic [16:0]        cur_mix;
  logic               started;
  logic [ADDR_W-1:0]  wr_pos;
  logic               wrapped;
  sample_t            dry;
  logic [ADDR_W-1:0]  lower;
  logic [ADDR_W-1:0]  upper;
  logic [15:0]        frac;
  logic               lo_ok;
  logic               hi_ok;
  sample_t            lo_data;
  sample_t            rdata;
  logic signed [41:0] interp;
  sample_t            delayed;
  logic signed [41:0] fb_prod;
  logic signed [41:0] mix_sum;
  logic               out_free;

  sample_t            ring [DEPTH];

  logic [31:0]        d_clamp;
  logic [31:0]        pos;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic               wr_en;
  sample_t            wr_data;
  sample_t            hi_data;

  always_comb begin
    d_clamp = (cur_delay > MAX_DELAY) ? MAX_DELAY : cur_delay;
    if (d_clamp < cfg.min_delay) begin
      d_clamp = cfg.min_delay;
    end
    // ring length in Q16.16 is exactly 2^32, so the wrap is free
    pos = {wr_pos, 16'd0} - d_clamp;
  end

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign rd_en    = (state == S_RDLO) || (state == S_RDHI);
  assign rd_addr  = (state == S_RDLO) ? lower : upper;
  assign wr_en    = (state == S_WRITE) && out_free;
  assign wr_data  = sat27(27'(dry) + 27'(round16(fb_prod)));
  assign hi_data  = hi_ok ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= ring[rd_addr];
    end
    if (wr_en) begin
      ring[wr_pos] <= wr_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dry <= q_data;
      end
      S_ADDR: begin
        lower <= pos[31:16];
        upper <= pos[31:16] + 16'd1;
        frac  <= pos[15:0];
        // entries never written read as zero
        lo_ok <= wrapped || (pos[31:16] < wr_pos);
        hi_ok <= wrapped || ((pos[31:16] + 16'd1) < wr_pos);
      end
      S_RDHI: begin
        lo_data <= lo_ok ? rdata : '0;
      end
      S_MUL: begin
        interp <= 42'(lo_data * $signed({1'b0, UNITY - {1'b0, frac}}))
                + 42'(hi_data * $signed({2'b0, frac}));
      end
      S_ROUND: begin
        delayed <= sat27(27'(round16(interp)));
      end
      S_PROD: begin
        fb_prod <= 42'(delayed * $signed({1'b0, cur_fb}));
        mix_sum <= 42'(dry * $signed({1'b0, UNITY - cur_mix}))
                 + 42'(delayed * $signed({1'b0, cur_mix}));
      end
      default: begin
      end
    endcase
  end

  // control and running parameters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_delay <= 32'd31457280;
      cur_fb    <= 17'd0;
      cur_mix   <= 17'd32768;
      started   <= 1'b0;
      wr_pos    <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!started && state != S_SMOOTH) begin
        if (load.delay_en) cur_delay <= load.delay;
        if (load.fb_en) cur_fb <= load.fb;
        if (load.mix_en) cur_mix <= load.mix;
      end
      if (out_valid && !out_stall && state != S_WRITE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) state <= S_SMOOTH;
        end
        S_SMOOTH: begin
          started   <= 1'b1;
          cur_delay <= smooth(cur_delay, cfg.target_delay, cfg.coeff);
          cur_fb    <= 17'(smooth(32'(cur_fb), 32'(cfg.target_feedback), cfg.coeff));
          cur_mix   <= 17'(smooth(32'(cur_mix), 32'(cfg.target_mix), cfg.coeff));
          state     <= S_ADDR;
        end
        S_ADDR:  state <= S_RDLO;
        S_RDLO:  state <= S_RDHI;
        S_RDHI:  state <= S_MUL;
        S_MUL:   state <= S_ROUND;
        S_ROUND: state <= S_PROD;
        S_PROD:  state <= S_WRITE;
        S_WRITE: begin
          // hold until the output register can take the result
          if (out_free) begin
            out_valid  <= 1'b1;
            wet_sample <= sat27(27'(round16(mix_sum)));
            wr_pos     <= wr_pos + 16'd1;
            if (wr_pos == 16'(DEPTH - 1)) wrapped <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/fractional_feedback_delay_line.sv
// Per sample the sequencer runs SMOOTH, ADDR, RDLO, RDHI, MUL, ROUND, PROD and
// WRITE, which holds while the output stalls; it takes the next sample in IDLE,
// sharing one ring port for two reads and one write per sample.
// Reset (synchronous, rst high): registers and running values take defaults;
// the ring reads as zero until written, tracked by the write pointer.
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line
// Feedback delay line with fractional delay, linear interpolation and mix.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line import ffdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  sample_t            dry_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output sample_t            wet_sample
);

  cfg_t      cfg;
  cfg_load_t load;
  logic      wr;
  logic      q_valid;
  sample_t   q_data;
  logic      q_pop;
  logic [15:0] fb_lim;
  logic [16:0] mix_lim;
  logic [16:0] coeff_lim;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  assign fb_lim    = (pwdata[15:0] > FB_MAX) ? FB_MAX : pwdata[15:0];
  assign mix_lim   = (pwdata[16:0] > UNITY) ? UNITY : pwdata[16:0];
  assign coeff_lim = mix_lim;

  always_comb begin
    load.delay_en = wr && (paddr == REG_TARGET_DELAY);
    load.delay    = pwdata;
    load.fb_en    = wr && (paddr == REG_TARGET_FB);
    load.fb       = {1'b0, fb_lim};
    load.mix_en   = wr && (paddr == REG_TARGET_MIX);
    load.mix      = mix_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_delay    <= 32'd31457280;
      cfg.min_delay       <= 32'd314573;
      cfg.target_feedback <= 16'd0;
      cfg.target_mix      <= 17'd32768;
      cfg.coeff           <= 17'd136;
    end else if (wr) begin
      case (paddr)
        REG_TARGET_DELAY: cfg.target_delay    <= pwdata;
        REG_MIN_DELAY:    cfg.min_delay       <= pwdata;
        REG_TARGET_FB:    cfg.target_feedback <= fb_lim;
        REG_TARGET_MIX:   cfg.target_mix      <= mix_lim;
        REG_COEFF:        cfg.coeff           <= coeff_lim;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_TARGET_DELAY: prdata = cfg.target_delay;
      REG_MIN_DELAY:    prdata = cfg.min_delay;
      REG_TARGET_FB:    prdata = {16'd0, cfg.target_feedback};
      REG_TARGET_MIX:   prdata = {15'd0, cfg.target_mix};
      REG_COEFF:        prdata = {15'd0, cfg.coeff};
      default:          prdata = 32'd0;
    endcase
  end

  ffdl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .dry_sample (dry_sample),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  ffdl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .load       (load),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .wet_sample (wet_sample)
  );

endmodule

>>> dv/fractional_feedback_delay_line_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line_tb
// Drives audio samples and APB register writes into the delay line, predicts
// every mixed output sample from a local model of the ring, smoothing and
// mix, and compares each output item with the oldest prediction.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line_tb;
  import ffdl_pkg::*;

  localparam logic [PADDR_W-1:0] REG_UNUSED = 5'd20;
  localparam int NUM_PHASES     = 10;
  localparam int ITEMS_PER_PH   = 155;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AT     = 700;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t dry_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t wet_sample;

  fractional_feedback_delay_line u_top (.*);

  always #6 clk = ~clk;

  // local copy of the block state and registers
  sample_t     ring [DEPTH];
  logic [15:0] wr_pos;
  logic [31:0] cur_delay, tgt_delay, min_dly;
  logic [16:0] cur_fb, tgt_fb, cur_mix, tgt_mix, coeff;
  logic        running;

  sample_t    pending_dry[$];
  sample_t    wet_expected[$];
  idle_mode_t idle_mode = IDLE_SEND_LIGHT;
  int         n_errors = 0;
  int         n_in = 0, n_out = 0;
  int         holdoff_left = 0;
  logic       held_once = 1'b0;
  int         quiet_cycles = 0;

  function automatic logic [31:0] glide(logic [31:0] cur, logic [31:0] tgt, logic [16:0] c);
    longint unsigned step;
    if (tgt >= cur) begin
      step = (longint'(tgt - cur) * longint'(c)) >> 16;
      return cur + step[31:0];
    end
    step = (longint'(cur - tgt) * longint'(c)) >> 16;
    return cur - step[31:0];
  endfunction

  function automatic longint round_q16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint clip(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic sample_t predict_wet(sample_t dry_in);
    longint dly, pos, dry, dl, wet;
    longint lo, hi, fr;
    running   = 1'b1;
    cur_delay = glide(cur_delay, tgt_delay, coeff);
    cur_fb    = 17'(glide({15'd0, cur_fb}, {15'd0, tgt_fb}, coeff));
    cur_mix   = 17'(glide({15'd0, cur_mix}, {15'd0, tgt_mix}, coeff));
    dry = longint'(dry_in);
    dly = longint'(cur_delay);
    if (dly > longint'(MAX_DELAY)) dly = longint'(MAX_DELAY);
    if (dly < longint'(min_dly)) dly = longint'(min_dly);
    pos = (longint'(wr_pos) << 16) + (64'sd1 << 32) - dly;
    if (pos >= (64'sd1 << 32)) pos -= (64'sd1 << 32);
    lo = pos >> 16;
    fr = pos & 64'hFFFF;
    hi = (lo + 1) % DEPTH;
    dl = clip(round_q16(longint'(ring[lo]) * (65536 - fr) + longint'(ring[hi]) * fr));
    ring[wr_pos] = sample_t'(clip(dry + round_q16(dl * longint'(cur_fb))));
    wet = clip(round_q16(dry * (65536 - longint'(cur_mix)) + dl * longint'(cur_mix)));
    wr_pos = wr_pos + 16'd1;
    return sample_t'(wet);
  endfunction

  // driver: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin
    logic idle;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        wet_expected.push_back(predict_wet(dry_sample));
        n_in++;
      end
      idle = (idle_mode == IDLE_SEND_LIGHT) ? ($urandom_range(99) < 27) :
             (idle_mode == IDLE_RECV_LIGHT) ? ($urandom_range(99) < 76) : 1'b0;
      if (in_valid && in_stall) begin
      end else if (pending_dry.size() > 0 && !idle) begin
        in_valid   <= 1'b1;
        dry_sample <= pending_dry.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check output items and drive the output stall
  always @(posedge clk) begin
    sample_t exp_wet;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (wet_expected.size() == 0) begin
          $error("unexpected output item wet_sample=%0d", wet_sample);
          n_errors++;
        end else begin
          exp_wet = wet_expected.pop_front();
          if (wet_sample !== exp_wet) begin
            $error("wet_sample mismatch: expected %0d, actual %0d", exp_wet, wet_sample);
            n_errors++;
          end
        end
      end
      if (!held_once && n_out >= HOLDOFF_AT) begin
        held_once    = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (idle_mode == IDLE_SEND_LIGHT) begin
        out_stall <= ($urandom_range(99) < 76);
      end else if (idle_mode == IDLE_RECV_LIGHT) begin
        out_stall <= ($urandom_range(99) < 27);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || rst ||
        holdoff_left > 0) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_TARGET_DELAY: begin
        tgt_delay = data;
        if (!running) cur_delay = data;
      end
      REG_MIN_DELAY: min_dly = data;
      REG_TARGET_FB: begin
        tgt_fb = (data[15:0] > FB_MAX) ? {1'b0, FB_MAX} : {1'b0, data[15:0]};
        if (!running) cur_fb = tgt_fb;
      end
      REG_TARGET_MIX: begin
        tgt_mix = (data[16:0] > UNITY) ? UNITY : data[16:0];
        if (!running) cur_mix = tgt_mix;
      end
      REG_COEFF: coeff = (data[16:0] > UNITY) ? UNITY : data[16:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_dry.size() != 0 || in_valid || wet_expected.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] td, md, fb, mx, cf;
    for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    wr_pos    = '0;
    cur_delay = 32'd31457280;
    tgt_delay = 32'd31457280;
    min_dly   = 32'd314573;
    cur_fb    = '0;
    tgt_fb    = '0;
    cur_mix   = 17'd32768;
    tgt_mix   = 17'd32768;
    coeff     = 17'd136;
    running   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_mode = (ph < 4) ? IDLE_SEND_LIGHT : (ph < 7) ? IDLE_RECV_LIGHT : IDLE_NONE;
      case (ph)
        0: begin td = 32'h000A_8000; md = 32'h0000_4000; fb = 32'd40000; mx = 32'd65536;
                 cf = 32'd65536; end
        1: begin td = 32'd0; md = 32'd0; fb = 32'h0000_FFFF; mx = 32'h0001_FFFF;
                 cf = 32'h0001_FFFF; end
        2: begin td = 32'hFFFF_FFFF; md = 32'd0; fb = 32'd0; mx = 32'd0;
                 cf = 32'd65536; end
        3: begin td = 32'h0003_0000; md = 32'hFFFF_FFFF; fb = 32'd62259; mx = 32'd49152;
                 cf = 32'd1; end
        4: begin td = $urandom; md = $urandom_range(32'h0010_0000); fb = $urandom;
                 mx = $urandom; cf = 32'd0; end
        default: begin
          td = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000);
          md = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0002_0000);
          fb = $urandom;
          mx = $urandom_range(65536);
          cf = $urandom_range(65536, 1);
        end
      endcase
      // early writes before the first item also load the running values
      reg_write(REG_TARGET_DELAY, td);
      reg_write(REG_MIN_DELAY, md);
      reg_write(REG_TARGET_FB, fb);
      reg_write(REG_TARGET_MIX, mx);
      reg_write(REG_COEFF, cf);
      if (ph == 1) reg_write(REG_UNUSED, $urandom);
      if (ph == 0) begin
        pending_dry.push_back(24'sh7FFFFF);
        pending_dry.push_back(-24'sh800000);
        pending_dry.push_back(24'sh000000);
        pending_dry.push_back(-24'sh000001);
        pending_dry.push_back(24'sh000001);
        pending_dry.push_back(24'sh555555);
        pending_dry.push_back(24'shAAAAAA);
        for (int k = 0; k < 14; k++)
          pending_dry.push_back((k % 2) ? 24'sh7FFFFF : -24'sh800000);
      end
      for (int k = 0; k < ITEMS_PER_PH; k++) pending_dry.push_back(sample_t'($urandom));
      wait_drained();
    end

    $display("Summary: %0d samples sent, %0d output items checked over %0d register settings",
             n_in, n_out, NUM_PHASES);
    $display("Covered early loads, zero and clamped delay, minimum override, limits, holdoff");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
